>>> design/hsa_pkg.sv
`timescale 1ns / 1ps
package hsa_pkg;

  typedef struct packed {
    logic [15:0] node_id;
    logic        last_node;
  } in_item_t;

  typedef struct packed {
    logic [15:0] assigned_node;
    logic [5:0]  slot_index;
    logic [27:0] offset_us;
    logic [27:0] superframe_us;
    logic        moved;
    logic        last_result;
  } out_item_t;

  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDataW = 20;
  localparam int unsigned SlotW = 6;
  localparam int unsigned TimeW = 28;

  localparam logic [CfgIdxW-1:0] CFG_BASE_SLOT = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_SF = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_RESOLVE = 2'd2;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_HASH,
    ST_SCAN,
    ST_RESOLVE,
    ST_SLOTLEN,
    ST_EMIT
  } state_e;

  function automatic logic [2:0] sf_mult(input logic [3:0] sf);
    unique case (sf)
      4'd7: sf_mult = 3'd1;
      4'd8: sf_mult = 3'd2;
      4'd9: sf_mult = 3'd3;
      default: sf_mult = 3'd4;
    endcase
  endfunction

endpackage

>>> design/hsa_modred.sv
`timescale 1ns / 1ps
// Restoring shift-subtract remainder unit: one quotient bit per cycle.
module hsa_modred #(
  parameter int unsigned IdBits = 16,
  parameter int unsigned CntW = 7
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [IdBits-1:0] dividend_i,
  input  logic [CntW-1:0]   divisor_i,
  output logic              done_o,
  output logic [CntW-1:0]   rem_o
);
  localparam int unsigned StepW = $clog2(IdBits + 1);

  logic [IdBits-1:0] shift_q, shift_d;
  logic [CntW:0]     rem_q, rem_d;
  logic [StepW-1:0]  step_q, step_d;
  logic              busy_q, busy_d;
  logic [CntW:0]     trial;

  always_comb begin
    shift_d = shift_q;
    rem_d   = rem_q;
    step_d  = step_q;
    busy_d  = busy_q;
    trial   = {rem_q[CntW-1:0], shift_q[IdBits-1]};
    if (start_i) begin
      shift_d = dividend_i;
      rem_d   = '0;
      step_d  = StepW'(IdBits);
      busy_d  = 1'b1;
    end else if (busy_q) begin
      shift_d = {shift_q[IdBits-2:0], 1'b0};
      rem_d   = (trial >= {1'b0, divisor_i}) ? trial - {1'b0, divisor_i} : trial;
      step_d  = step_q - 1'b1;
      if (step_q == StepW'(1)) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    shift_q <= shift_d;
    rem_q   <= rem_d;
  end

  assign done_o = busy_q && (step_q == StepW'(1));
  assign rem_o  = rem_d[CntW-1:0];
endmodule

>>> design/hashed_slot_assigner_top.sv
`timescale 1ns / 1ps
// Hashed slot assigner for one spreading-factor group. Node IDs are loaded at
// one item per cycle while the block is idle; the item flagged last_node
// closes the group of N nodes (at most MAX_NODES; later IDs are dropped but a
// last flag still closes it). The block then goes busy and accepts no item
// until every result has been taken. Each node hashes to id mod N through a
// shared restoring remainder unit, which works through the kept ID bits one
// at a time after a start. A scan over N slots builds a free-slot stack, and
// with resolve_enable set the resolve pass walks each slot against every
// node, so the first node keeps the slot and each later one pops the largest
// free slot. Slot length and the superframe length are formed one after the
// other by one shared multiplier, then one result per node leaves in load
// order, its offset formed by the same multiplier. Results leave one per
// cycle while the receiver keeps up. The stores are read through registered
// ports addressed with the next index, so read data is there when the index
// is. Configuration must be written only while the block is idle; the block
// itself does not enforce this.
module hashed_slot_assigner_top #(
  parameter int unsigned MAX_NODES = 64,
  parameter int unsigned ID_BITS = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  hsa_pkg::in_item_t                 in_data_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output hsa_pkg::out_item_t                out_data_o,
  input  logic                              cfg_we_i,
  input  logic [hsa_pkg::CfgIdxW-1:0]       cfg_idx_i,
  input  logic [hsa_pkg::CfgDataW-1:0]      cfg_data_i
);
  import hsa_pkg::*;

  localparam int unsigned IdxW = $clog2(MAX_NODES);
  localparam int unsigned CntW = $clog2(MAX_NODES + 1);
  // Only the low ID bits that fit the 16-bit node field are ever kept.
  localparam int unsigned IdW = (ID_BITS < 16) ? ID_BITS : 16;

  // Configuration registers.
  logic [19:0] base_q;
  logic [3:0]  sf_q;
  logic        res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q <= 20'd200000;
      sf_q   <= 4'd7;
      res_q  <= 1'b1;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_BASE_SLOT: base_q <= cfg_data_i;
        CFG_SF:        sf_q   <= cfg_data_i[3:0];
        CFG_RESOLVE:   res_q  <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Stores.
  logic [IdW-1:0]     id_mem   [MAX_NODES];
  logic [SlotW-1:0]   slot_mem [MAX_NODES];
  logic [SlotW-1:0]   free_mem [MAX_NODES];
  logic [MAX_NODES-1:0] taken_q, taken_d, moved_q, moved_d;

  state_e st_q, st_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [IdxW-1:0] i_q, i_d;     // node index
  logic [CntW-1:0] s_q, s_d;     // slot index
  logic [CntW-1:0] top_q, top_d;
  logic            first_q, first_d;
  logic            div_go_q, div_go_d;
  logic [22:0]     slen_q, slen_d;
  logic [TimeW-1:0] sframe_q, sframe_d;
  logic            ovalid_q, ovalid_d;
  out_item_t       odata_q, odata_d;
  logic            div_done;
  logic [CntW-1:0] rem;
  logic [IdW-1:0]     id_rd_q;
  logic [SlotW-1:0]   slot_rd_q, free_rd_q;
  logic            id_we, slot_we, free_we;
  logic [SlotW-1:0] slot_wdata;
  logic [IdxW-1:0]  free_waddr;
  logic [IdxW-1:0]  free_raddr;
  logic [29:0]     prod;
  logic [22:0]     mul_a;
  logic [6:0]      mul_b;
  logic            last_i;
  logic [CntW-1:0] top_dec;

  assign top_dec    = top_q - 1'b1;
  // The stack top is read ahead through the registered port, at the entry below the next top.
  assign free_raddr = IdxW'(top_d - 1'b1);
  assign last_i     = (i_q == IdxW'(cnt_q - 1'b1));
  assign prod       = mul_a * mul_b;

  hsa_modred #(.IdBits(IdW), .CntW(CntW)) u_mod (
    .clk_i, .rst_ni,
    .start_i(div_go_q), .dividend_i(id_rd_q), .divisor_i(cnt_q),
    .done_o(div_done), .rem_o(rem)
  );

  always_comb begin
    st_d = st_q; cnt_d = cnt_q; i_d = i_q; s_d = s_q; top_d = top_q;
    first_d = first_q; div_go_d = 1'b0; slen_d = slen_q; sframe_d = sframe_q;
    ovalid_d = ovalid_q; odata_d = odata_q; taken_d = taken_q; moved_d = moved_q;
    id_we = 1'b0; slot_we = 1'b0; free_we = 1'b0;
    slot_wdata = SlotW'(rem); free_waddr = top_q[IdxW-1:0];
    mul_a = 23'(base_q); mul_b = 7'(sf_mult(sf_q));
    in_ready_o = 1'b0;
    unique case (st_q)
      ST_LOAD: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          if (cnt_q < CntW'(MAX_NODES)) begin
            id_we = 1'b1;
            cnt_d = cnt_q + 1'b1;
          end
          if (in_data_i.last_node) begin
            if (cnt_d == '0) begin
              cnt_d = '0;
            end else begin
              st_d = ST_HASH; i_d = '0; div_go_d = 1'b1;
            end
          end
        end
      end
      ST_HASH: begin
        if (div_done) begin
          slot_we = 1'b1;
          taken_d[rem[IdxW-1:0]] = 1'b1;
          if (last_i) begin
            st_d = ST_SCAN; s_d = '0; top_d = '0;
          end else begin
            i_d = i_q + 1'b1; div_go_d = 1'b1;
          end
        end
      end
      ST_SCAN: begin
        if (!taken_q[s_q[IdxW-1:0]]) begin
          free_we = 1'b1; top_d = top_q + 1'b1;
        end
        if (s_q == cnt_q - 1'b1) begin
          s_d = '0; i_d = '0; first_d = 1'b1;
          st_d = res_q ? ST_RESOLVE : ST_SLOTLEN;
        end else begin
          s_d = s_q + 1'b1;
        end
      end
      ST_RESOLVE: begin
        if (taken_q[s_q[IdxW-1:0]] && !moved_q[i_q]
            && ({1'b0, slot_rd_q} == 7'(s_q))) begin
          if (first_q) begin
            first_d = 1'b0;
          end else if (top_q != '0) begin
            top_d = top_dec; slot_we = 1'b1; slot_wdata = free_rd_q;
            moved_d[i_q] = 1'b1;
          end
        end
        if (last_i) begin
          i_d = '0; first_d = 1'b1;
          if (s_q == cnt_q - 1'b1) st_d = ST_SLOTLEN;
          else s_d = s_q + 1'b1;
        end else begin
          i_d = i_q + 1'b1;
        end
      end
      ST_SLOTLEN: begin
        // Slot length first, then superframe on the second visit.
        if (!first_q) begin
          mul_a = slen_q; mul_b = 7'(cnt_q);
          sframe_d = prod[TimeW-1:0];
          st_d = ST_EMIT; i_d = '0;
        end else begin
          slen_d = prod[22:0]; first_d = 1'b0;
        end
      end
      ST_EMIT: begin
        mul_a = slen_q; mul_b = 7'(slot_rd_q);
        if (out_ready_i || !ovalid_q) begin
          if (ovalid_q && odata_q.last_result) begin
            ovalid_d = 1'b0;
            st_d = ST_LOAD; cnt_d = '0; taken_d = '0; moved_d = '0;
            top_d = '0;
          end else begin
            ovalid_d = 1'b1;
            odata_d.assigned_node = 16'(id_rd_q);
            odata_d.slot_index = slot_rd_q;
            odata_d.offset_us = prod[TimeW-1:0];
            odata_d.superframe_us = sframe_q;
            odata_d.moved = moved_q[i_q];
            odata_d.last_result = last_i;
            if (!last_i) i_d = i_q + 1'b1;
          end
        end
      end
      default: st_d = ST_LOAD;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= ST_LOAD; cnt_q <= '0; i_q <= '0; s_q <= '0; top_q <= '0;
      first_q <= 1'b1; div_go_q <= 1'b0; ovalid_q <= 1'b0;
      taken_q <= '0; moved_q <= '0;
    end else begin
      st_q <= st_d; cnt_q <= cnt_d; i_q <= i_d; s_q <= s_d; top_q <= top_d;
      first_q <= first_d; div_go_q <= div_go_d; ovalid_q <= ovalid_d;
      taken_q <= taken_d; moved_q <= moved_d;
    end
  end

  // Store ports. Reads are registered at the index of the next cycle; an ID or
  // free slot written at the address being read is passed straight through.
  always_ff @(posedge clk_i) begin
    slen_q <= slen_d; sframe_q <= sframe_d; odata_q <= odata_d;
    if (id_we) id_mem[cnt_q[IdxW-1:0]] <= in_data_i.node_id[IdW-1:0];
    if (slot_we) slot_mem[i_q] <= slot_wdata;
    if (free_we) free_mem[free_waddr] <= SlotW'(s_q);
    id_rd_q   <= (id_we && (cnt_q[IdxW-1:0] == i_d)) ? in_data_i.node_id[IdW-1:0]
                                                     : id_mem[i_d];
    slot_rd_q <= slot_mem[i_d];
    free_rd_q <= (free_we && (free_waddr == free_raddr)) ? SlotW'(s_q)
                                                         : free_mem[free_raddr];
  end

  assign out_valid_o = ovalid_q;
  assign out_data_o  = odata_q;

  a_busy_not_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q != ST_LOAD) |-> !in_ready_o) else $error("ready while busy");
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(MAX_NODES)) else $error("node count overflow");
  a_out_only_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (st_q == ST_EMIT)) else $error("result outside emit");
  a_top_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    top_q <= cnt_q) else $error("free stack overflow");
endmodule

>>> tb/hashed_slot_assigner_top_tb.sv
`timescale 1ns / 1ps
// Testbench for the hashed slot assigner. Node IDs are sent as items on the
// input channel; whenever an item closes a group, a software copy of the slot
// assignment works out the expected results, which are then checked in order
// against every item that leaves the output channel.
module hashed_slot_assigner_top_tb;
  import hsa_pkg::*;

  localparam int unsigned MaxNodes = 64;
  localparam int unsigned ExpDepth = 128;
  localparam int unsigned CycleLimit = 2000000;
  localparam int unsigned SettleCycles = 20;
  localparam int unsigned HoldCycles = 400;
  // Index 3 is outside the register list and must be ignored by the block.
  localparam logic [CfgIdxW-1:0] CFG_UNUSED = 2'd3;

  logic clk_i;
  logic rst_ni;
  logic in_valid_i;
  logic in_ready_o;
  in_item_t in_data_i;
  logic out_valid_o;
  logic out_ready_i;
  out_item_t out_data_o;
  logic cfg_we_i;
  logic [CfgIdxW-1:0] cfg_idx_i;
  logic [CfgDataW-1:0] cfg_data_i;

  hashed_slot_assigner_top u_dut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .in_valid_i(in_valid_i),
    .in_ready_o(in_ready_o),
    .in_data_i(in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o(out_data_o),
    .cfg_we_i(cfg_we_i),
    .cfg_idx_i(cfg_idx_i),
    .cfg_data_i(cfg_data_i)
  );

  // Shadow copy of the configuration registers.
  logic [19:0] base_slot_q;
  logic [3:0] sf_q;
  logic resolve_q;

  // IDs of the group that is being loaded, and a ring of the results still
  // owed: the sender fills it at exp_wr, the checker drains it at exp_rd.
  logic [15:0] group_ids[MaxNodes];
  int group_cnt;
  out_item_t exp_mem[ExpDepth];
  int unsigned exp_wr = 0;
  int unsigned exp_rd = 0;

  int unsigned errors = 0;
  int unsigned cycles = 0;
  int unsigned items_sent;
  int unsigned groups_closed;
  int unsigned results_seen = 0;
  int unsigned send_gap_pct;
  int unsigned stall_pct;
  // Each increment asks the receiver for one long stall.
  int unsigned hold_req = 0;
  int unsigned hold_seen = 0;
  int unsigned hold_left = 0;

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // The watchdog ends a run that hangs.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("%0t: timeout after %0d cycles", $time, cycles);
      $display("TEST FAILED");
      $finish;
    end
  end

  // Multiplier of the slot length per spreading factor; any factor other than
  // the known ones falls back to the largest multiplier.
  function automatic logic [2:0] slot_mult(input logic [3:0] sf);
    case (sf)
      4'd7: return 3'd1;
      4'd8: return 3'd2;
      4'd9: return 3'd3;
      default: return 3'd4;
    endcase
  endfunction

  // Runs the hash and collision resolution over the group just closed and
  // queues one expected result per node, in load order.
  task automatic assign_slots();
    int n;
    int top;
    logic [5:0] slots[MaxNodes];
    logic [5:0] free_stack[MaxNodes];
    bit taken[MaxNodes];
    bit moved[MaxNodes];
    bit first;
    logic [31:0] slot_len;
    logic [31:0] superframe;
    logic [31:0] offset;
    out_item_t r;
    n = group_cnt;
    top = 0;
    for (int i = 0; i < MaxNodes; i++) begin
      taken[i] = 1'b0;
      moved[i] = 1'b0;
    end
    for (int i = 0; i < n; i++) begin
      slots[i] = 6'(group_ids[i] % n);
      taken[slots[i]] = 1'b1;
    end
    for (int s = 0; s < n; s++) begin
      if (!taken[s]) begin
        free_stack[top] = 6'(s);
        top++;
      end
    end
    if (resolve_q) begin
      for (int s = 0; s < n; s++) begin
        if (!taken[s]) continue;
        first = 1'b1;
        for (int i = 0; i < n; i++) begin
          if (moved[i] || slots[i] != 6'(s)) continue;
          if (first) begin
            first = 1'b0;
          end else if (top > 0) begin
            top--;
            slots[i] = free_stack[top];
            moved[i] = 1'b1;
          end
        end
      end
    end
    slot_len = 32'(base_slot_q) * 32'(slot_mult(sf_q));
    superframe = slot_len * 32'(n);
    for (int i = 0; i < n; i++) begin
      offset = 32'(slots[i]) * slot_len;
      r.assigned_node = group_ids[i];
      r.slot_index = slots[i];
      r.offset_us = offset[27:0];
      r.superframe_us = superframe[27:0];
      r.moved = moved[i];
      r.last_result = (i == n - 1);
      exp_mem[exp_wr % ExpDepth] = r;
      exp_wr++;
    end
    group_cnt = 0;
    groups_closed++;
  endtask

  // Sends one item: optional idle cycles first, then valid stays high with the
  // payload held until the block takes it. Valid is left high on return so a
  // back-to-back item does not toggle it within one time step.
  task automatic send_node(input logic [15:0] id, input logic last);
    while ($urandom_range(0, 99) < send_gap_pct) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    in_data_i.node_id = id;
    in_data_i.last_node = last;
    do @(posedge clk_i); while (!in_ready_o);
    items_sent++;
    // Once the group is full, further IDs are dropped, but a last flag still
    // closes the group.
    if (group_cnt < MaxNodes) begin
      group_ids[group_cnt] = id;
      group_cnt++;
    end
    if (last) assign_slots();
    @(negedge clk_i);
  endtask

  task automatic stop_sending();
    in_valid_i = 1'b0;
  endtask

  // Waits until every owed result has come, then lets the block settle.
  task automatic wait_drained();
    stop_sending();
    while (exp_rd != exp_wr) @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  // Register write; only issued while the block is idle.
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [19:0] value);
    cfg_we_i = 1'b1;
    cfg_idx_i = idx;
    cfg_data_i = value;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    case (idx)
      CFG_BASE_SLOT: base_slot_q = value;
      CFG_SF: sf_q = value[3:0];
      CFG_RESOLVE: resolve_q = value[0];
      default: ;
    endcase
  endtask

  task automatic send_group(input int n, input bit collide);
    logic [15:0] id;
    for (int i = 0; i < n; i++) begin
      // Small IDs make collisions and duplicates common.
      id = collide ? 16'($urandom_range(0, 2 * n + 1)) : 16'($urandom);
      send_node(id, i == n - 1);
    end
  endtask

  // The receiver accepts at random, or holds off entirely for a long stretch
  // each time one is requested.
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      out_ready_i = 1'b0;
    end else begin
      if (hold_req != hold_seen) begin
        hold_seen = hold_req;
        hold_left = HoldCycles;
      end
      if (hold_left != 0) begin
        out_ready_i = 1'b0;
        hold_left = hold_left - 1;
      end else begin
        out_ready_i = ($urandom_range(0, 99) >= stall_pct);
      end
    end
  end

  // Every accepted result is compared with the oldest expectation.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      results_seen++;
      if (exp_rd == exp_wr) begin
        errors++;
        $display("%0t: unexpected result %p", $time, out_data_o);
      end else begin
        out_item_t want;
        want = exp_mem[exp_rd % ExpDepth];
        exp_rd++;
        if (want.assigned_node !== out_data_o.assigned_node) begin
          errors++;
          $display("%0t: assigned_node expected %0d got %0d", $time,
                   want.assigned_node, out_data_o.assigned_node);
        end
        if (want.slot_index !== out_data_o.slot_index) begin
          errors++;
          $display("%0t: slot_index expected %0d got %0d", $time,
                   want.slot_index, out_data_o.slot_index);
        end
        if (want.offset_us !== out_data_o.offset_us) begin
          errors++;
          $display("%0t: offset_us expected %0d got %0d", $time,
                   want.offset_us, out_data_o.offset_us);
        end
        if (want.superframe_us !== out_data_o.superframe_us) begin
          errors++;
          $display("%0t: superframe_us expected %0d got %0d", $time,
                   want.superframe_us, out_data_o.superframe_us);
        end
        if (want.moved !== out_data_o.moved) begin
          errors++;
          $display("%0t: moved expected %0b got %0b", $time,
                   want.moved, out_data_o.moved);
        end
        if (want.last_result !== out_data_o.last_result) begin
          errors++;
          $display("%0t: last_result expected %0b got %0b", $time,
                   want.last_result, out_data_o.last_result);
        end
      end
    end
  end

  // Field extremes, a lone node, all nodes on one slot with duplicate IDs,
  // and resolution switched off.
  task automatic test_directed();
    send_node(16'h0000, 1'b1);
    send_node(16'hFFFF, 1'b0);
    send_node(16'h0000, 1'b0);
    send_node(16'h5555, 1'b0);
    send_node(16'hAAAA, 1'b1);
    send_node(16'd9, 1'b0);
    send_node(16'd9, 1'b0);
    send_node(16'd9, 1'b0);
    send_node(16'd13, 1'b1);
    wait_drained();
    write_reg(CFG_RESOLVE, 20'd0);
    send_node(16'd4, 1'b0);
    send_node(16'd8, 1'b0);
    send_node(16'd1, 1'b1);
    wait_drained();
    write_reg(CFG_RESOLVE, 20'd1);
  endtask

  // A group larger than the store: the extra IDs, the closing one included,
  // are dropped. All IDs share one hash so every node but one is reassigned.
  task automatic test_overflow();
    for (int i = 0; i < MaxNodes + 2; i++) begin
      send_node(16'(i * MaxNodes), i == MaxNodes + 1);
    end
    wait_drained();
  endtask

  // Configuration extremes, unknown spreading factors and the unused index.
  task automatic test_config_sweep();
    logic [19:0] bases[4];
    logic [3:0] sfs[4];
    bases = '{20'd0, 20'd1, 20'hFFFFF, 20'd200000};
    sfs = '{4'd12, 4'd8, 4'd15, 4'd9};
    for (int k = 0; k < 4; k++) begin
      write_reg(CFG_BASE_SLOT, bases[k]);
      write_reg(CFG_SF, 20'(sfs[k]));
      send_group(k == 2 ? MaxNodes : 5, 1'b1);
      wait_drained();
    end
    write_reg(CFG_UNUSED, 20'($urandom));
    write_reg(CFG_SF, 20'd0);
    send_group(4, 1'b1);
    wait_drained();
    write_reg(CFG_SF, 20'd10);
    write_reg(CFG_BASE_SLOT, 20'd200000);
  endtask

  // Results are refused for a long stretch while the sender keeps offering the
  // next group, so the block fills and stops taking items.
  task automatic test_backpressure();
    hold_req++;
    send_group(8, 1'b1);
    send_group(6, 1'b1);
    wait_drained();
  endtask

  // Random groups in three idling phases, with new settings between phases.
  task automatic test_random();
    int target;
    int n;
    for (int phase = 0; phase < 3; phase++) begin
      send_gap_pct = (phase == 0) ? 30 : (phase == 1) ? 46 : 0;
      stall_pct = (phase == 0) ? 46 : (phase == 1) ? 30 : 0;
      write_reg(CFG_BASE_SLOT, 20'($urandom_range(1, 1000000)));
      write_reg(CFG_SF, 20'($urandom_range(7, 12)));
      write_reg(CFG_RESOLVE, 20'($urandom_range(0, 1)));
      target = items_sent + 92;
      while (items_sent < target) begin
        // Mostly short groups; a full-size group now and then.
        n = ($urandom_range(0, 99) < 3) ? MaxNodes : $urandom_range(1, 12);
        send_group(n, $urandom_range(0, 1));
      end
      wait_drained();
    end
  endtask

  initial begin
    items_sent = 0;
    groups_closed = 0;
    group_cnt = 0;
    send_gap_pct = 0;
    stall_pct = 0;
    base_slot_q = 20'd200000;
    sf_q = 4'd7;
    resolve_q = 1'b1;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    in_data_i = '0;
    cfg_we_i = 1'b0;
    cfg_idx_i = '0;
    cfg_data_i = '0;
    repeat (6) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_directed();
    test_overflow();
    test_config_sweep();
    test_backpressure();
    test_random();
    wait_drained();

    $display("Covered %0d items in %0d groups, %0d results checked,", items_sent,
             groups_closed, results_seen);
    $display("including overflow, collisions, config extremes and long stalls.");
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("%0d mismatches", errors);
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

>>> sim.f
design/hsa_pkg.sv
design/hsa_modred.sv
design/hashed_slot_assigner_top.sv
tb/hashed_slot_assigner_top_tb.sv
